>>> rtl/core/sqpc_pkg.sv
// Package for the serial/quad PSRAM controller: sizes, codes and shared types.
// Used by the channel interfaces, the transfer engine and the top level.
`default_nettype none

package sqpc_pkg;

  localparam int ADDR_BITS = 24;
  localparam int LEN_BITS  = 16;
  localparam int ADDR_NIB  = (ADDR_BITS + 3) / 4;
  localparam int TX_BITS   = 8 + 4 * ADDR_NIB;
  localparam int BC_W      = $clog2(TX_BITS + 1);

  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_FREAD = 8'h0B;
  localparam logic [7:0] OPC_WRITE = 8'h02;
  localparam logic [7:0] OPC_ENTER = 8'h35;
  localparam logic [7:0] OPC_EXIT  = 8'hF5;
  localparam logic [7:0] OPC_ID    = 8'h9F;

  localparam logic [3:0] DUMMY_RESET = 4'd4;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_ID    = 3'd3,
    CMD_ENTER = 3'd4,
    CMD_EXIT  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_SREAD = 3'd1,
    OP_WRITE = 3'd2,
    OP_ID    = 3'd3,
    OP_ENTER = 3'd4,
    OP_EXIT  = 3'd5,
    OP_QREAD = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_DUMMY = 3'd2,
    PH_RX    = 3'd3,
    PH_TX    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_MODE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [23:0] addr;
    logic [15:0] length;
    logic [7:0]  write_byte;
    logic        miso_in;
    logic [3:0]  dq_in;
  } sqpc_item_t;

  typedef struct packed {
    logic       cs_n;
    logic       sck_pulse;
    logic [3:0] dq_out;
    logic [3:0] dq_oe;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       write_taken;
    logic       done_res;
    logic [1:0] status;
  } sqpc_res_t;

endpackage

`default_nettype wire

>>> rtl/core/sqpc_if.sv
// Valid/ready channel interfaces of the PSRAM controller: request, result and
// configuration write. Imports sqpc_pkg; the port widths are written out as literals.
`default_nettype none

interface sqpc_in_if import sqpc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [23:0] addr;
  logic [15:0] length;
  logic [7:0]  write_byte;
  logic        miso_in;
  logic [3:0]  dq_in;

  modport source (output valid, cmd, addr, length, write_byte, miso_in, dq_in,
                  input ready);
  modport sink (input valid, cmd, addr, length, write_byte, miso_in, dq_in,
                output ready);
endinterface

interface sqpc_out_if import sqpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       cs_n;
  logic       sck_pulse;
  logic [3:0] dq_out;
  logic [3:0] dq_oe;
  logic [7:0] rx_byte;
  logic       rx_valid;
  logic       write_taken;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, cs_n, sck_pulse, dq_out, dq_oe, rx_byte, rx_valid,
                  write_taken, done_res, status, input ready);
  modport sink (input valid, cs_n, sck_pulse, dq_out, dq_oe, rx_byte, rx_valid,
                write_taken, done_res, status, output ready);
endinterface

interface sqpc_cfg_if import sqpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] quad_dummy_clocks;

  modport source (output valid, quad_dummy_clocks, input ready);
  modport sink (input valid, quad_dummy_clocks, output ready);
endinterface

`default_nettype wire

>>> rtl/core/spi_qpi_psram_controller_top.sv
// A request word's result is registered and shown in the cycle after acceptance.
// Throughput: one request word per cycle; each word is one bus clock of the PSRAM link.
// The request side keeps accepting while a result waits, as long as the output register
// is free or is being emptied in the same cycle.
// Reset (rst_n, synchronous, active low) returns to idle SPI mode with no pending result
// and sets the quad dummy clock count to 4.
`default_nettype none

module spi_qpi_psram_controller_top import sqpc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  sqpc_in_if.sink    in_chan,
  sqpc_out_if.source out_chan,
  sqpc_cfg_if.sink   cfg_chan
);

  logic       out_valid_r;
  sqpc_res_t  res_r;
  sqpc_res_t  res;
  sqpc_item_t item;
  logic [3:0] dummy_cfg_r;
  logic       in_ready;
  logic       accept;

  assign in_ready       = !out_valid_r || out_chan.ready;
  assign accept         = in_chan.valid && in_ready;
  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  assign item.cmd        = in_chan.cmd;
  assign item.addr       = in_chan.addr;
  assign item.length     = in_chan.length;
  assign item.write_byte = in_chan.write_byte;
  assign item.miso_in    = in_chan.miso_in;
  assign item.dq_in      = in_chan.dq_in;

  sqpc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .item      (item),
    .dummy_cfg (dummy_cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dummy_cfg_r <= DUMMY_RESET;
    end else if (cfg_chan.valid) begin
      dummy_cfg_r <= cfg_chan.quad_dummy_clocks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.cs_n        = res_r.cs_n;
  assign out_chan.sck_pulse   = res_r.sck_pulse;
  assign out_chan.dq_out      = res_r.dq_out;
  assign out_chan.dq_oe       = res_r.dq_oe;
  assign out_chan.rx_byte     = res_r.rx_byte;
  assign out_chan.rx_valid    = res_r.rx_valid;
  assign out_chan.write_taken = res_r.write_taken;
  assign out_chan.done_res    = res_r.done_res;
  assign out_chan.status      = res_r.status;

endmodule

`default_nettype wire

>>> rtl/core/sqpc_engine.sv
// Transfer engine: bus state registers and the per-word step logic.
// Depends on sqpc_pkg for codes, sizes and the word and result types.
`default_nettype none

module sqpc_engine import sqpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire sqpc_item_t item,
  input  wire logic [3:0] dummy_cfg,
  output sqpc_res_t       res
);

  phase_t               phase_r, phase_nxt;
  op_t                  op_r, op_nxt;
  logic                 quad_r, quad_nxt;
  logic [TX_BITS-1:0]   tx_r, tx_nxt;
  logic [BC_W-1:0]      bc_r, bc_nxt;
  logic [LEN_BITS-1:0]  left_r, left_nxt;
  logic [7:0]           rx_r, rx_nxt;
  logic [3:0]           dummy_r, dummy_nxt;

  logic [31:0]          addr_wide;
  logic [ADDR_BITS-1:0] addr_a;
  logic [23:0]          len_wide;
  logic [LEN_BITS-1:0]  len_a;
  logic                 wide;
  logic                 new_wide;
  logic [BC_W-1:0]      w;
  logic [BC_W-1:0]      bc_dec;
  logic [LEN_BITS-1:0]  left_dec;
  logic [7:0]           rx_new;
  logic [7:0]           tx_byte;
  logic [BC_W-1:0]      tx_bc;
  logic [3:0]           dummy_dec;

  function automatic logic [3:0] cmd_unit(logic [TX_BITS-1:0] tx, logic [BC_W-1:0] bc,
                                          logic wd);
    logic [BC_W-1:0]    uw;
    logic [TX_BITS-1:0] sh;
    uw = wd ? BC_W'(4) : BC_W'(1);
    sh = tx >> (bc - uw);
    if (bc < uw) begin
      return 4'd0;
    end
    return wd ? sh[3:0] : {3'b000, sh[0]};
  endfunction

  assign addr_wide = {8'h00, item.addr};
  assign addr_a    = addr_wide[ADDR_BITS-1:0];
  assign len_wide  = {8'h00, item.length};
  assign len_a     = len_wide[LEN_BITS-1:0];
  assign wide      = (op_r == OP_QREAD) || (op_r == OP_EXIT);
  assign w         = wide ? BC_W'(4) : BC_W'(1);
  assign left_dec  = left_r - LEN_BITS'(1);
  assign dummy_dec = dummy_r - 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= OP_NONE;
      quad_r  <= 1'b0;
      tx_r    <= '0;
      bc_r    <= '0;
      left_r  <= '0;
      rx_r    <= '0;
      dummy_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      quad_r  <= quad_nxt;
      tx_r    <= tx_nxt;
      bc_r    <= bc_nxt;
      left_r  <= left_nxt;
      rx_r    <= rx_nxt;
      dummy_r <= dummy_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    quad_nxt  = quad_r;
    tx_nxt    = tx_r;
    bc_nxt    = bc_r;
    left_nxt  = left_r;
    rx_nxt    = rx_r;
    dummy_nxt = dummy_r;
    new_wide  = 1'b0;
    bc_dec    = (bc_r >= w) ? bc_r - w : '0;
    rx_new    = (op_r == OP_QREAD) ? {rx_r[3:0], item.dq_in} : {rx_r[6:0], item.miso_in};
    tx_byte   = tx_r[7:0];
    tx_bc     = bc_r;
    res       = '0;
    res.cs_n  = 1'b1;
    res.status = ST_OK;

    unique case (phase_r)
      PH_IDLE: begin
        if (item.cmd != CMD_TICK) begin
          op_nxt = OP_NONE;
          if (!quad_r) begin
            if (item.cmd == CMD_READ || item.cmd == CMD_WRITE || item.cmd == CMD_ID ||
                item.cmd == CMD_ENTER) begin
              op_nxt = op_t'(item.cmd);
            end
          end else if (item.cmd == CMD_READ) begin
            op_nxt = OP_QREAD;
          end else if (item.cmd == CMD_EXIT) begin
            op_nxt = OP_EXIT;
          end
          if (op_nxt == OP_NONE) begin
            op_nxt     = op_r;
            res.status = ST_MODE;
          end else begin
            left_nxt  = '0;
            dummy_nxt = '0;
            bc_nxt    = BC_W'(8 + ADDR_BITS);
            unique case (op_nxt)
              OP_SREAD: begin
                tx_nxt   = TX_BITS'({OPC_READ, addr_a});
                left_nxt = len_a;
              end
              OP_WRITE: begin
                tx_nxt   = TX_BITS'({OPC_WRITE, addr_a});
                left_nxt = len_a;
              end
              OP_ID: begin
                tx_nxt   = TX_BITS'({OPC_ID, {ADDR_BITS{1'b0}}});
                left_nxt = LEN_BITS'(2);
              end
              OP_ENTER: begin
                tx_nxt = TX_BITS'(OPC_ENTER);
                bc_nxt = BC_W'(8);
              end
              OP_EXIT: begin
                tx_nxt = TX_BITS'(OPC_EXIT);
                bc_nxt = BC_W'(8);
              end
              default: begin
                tx_nxt    = {OPC_FREAD, (4 * ADDR_NIB)'(addr_a)};
                bc_nxt    = BC_W'(TX_BITS);
                left_nxt  = len_a;
                dummy_nxt = dummy_cfg;
              end
            endcase
            new_wide   = (op_nxt == OP_QREAD) || (op_nxt == OP_EXIT);
            phase_nxt  = PH_CMD;
            res.cs_n   = 1'b0;
            res.dq_oe  = new_wide ? 4'hF : 4'h1;
            res.dq_out = cmd_unit(tx_nxt, bc_nxt, new_wide);
          end
        end
      end
      PH_CMD: begin
        res.dq_oe  = wide ? 4'hF : 4'h1;
        res.dq_out = cmd_unit(tx_r, bc_r, wide);
        bc_nxt     = bc_dec;
        if (bc_dec == '0) begin
          priority case (op_r)
            OP_QREAD, OP_SREAD, OP_ID: begin
              if (op_r == OP_QREAD && dummy_r != 4'd0) begin
                phase_nxt = PH_DUMMY;
              end else if (left_r == '0) begin
                phase_nxt    = PH_IDLE;
                res.done_res = 1'b1;
              end else begin
                phase_nxt = PH_RX;
                bc_nxt    = BC_W'(8);
                rx_nxt    = '0;
              end
            end
            OP_WRITE: begin
              if (left_r == '0) begin
                phase_nxt    = PH_IDLE;
                res.done_res = 1'b1;
              end else begin
                phase_nxt = PH_TX;
              end
            end
            OP_ENTER: begin
              quad_nxt     = 1'b1;
              phase_nxt    = PH_IDLE;
              res.done_res = 1'b1;
            end
            default: begin
              quad_nxt     = 1'b0;
              phase_nxt    = PH_IDLE;
              res.done_res = 1'b1;
            end
          endcase
        end
      end
      PH_DUMMY: begin
        dummy_nxt = dummy_dec;
        if (dummy_dec == 4'd0) begin
          if (left_r == '0) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
          end else begin
            phase_nxt = PH_RX;
            bc_nxt    = BC_W'(8);
            rx_nxt    = '0;
          end
        end
      end
      PH_RX: begin
        rx_nxt = rx_new;
        bc_nxt = bc_dec;
        if (bc_dec == '0) begin
          res.rx_valid = 1'b1;
          res.rx_byte  = rx_new;
          left_nxt     = left_dec;
          if (left_dec == '0) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
          end else begin
            bc_nxt = BC_W'(8);
            rx_nxt = '0;
          end
        end
      end
      default: begin
        if (bc_r == '0 || bc_r > BC_W'(8)) begin
          tx_byte         = item.write_byte;
          tx_bc           = BC_W'(8);
          res.write_taken = 1'b1;
        end
        tx_nxt     = TX_BITS'(tx_byte);
        res.dq_oe  = 4'h1;
        res.dq_out = {3'b000, tx_byte[3'(tx_bc - BC_W'(1))]};
        bc_nxt     = tx_bc - BC_W'(1);
        if (bc_nxt == '0) begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
          end
        end
      end
    endcase

    if (phase_r != PH_IDLE) begin
      res.cs_n      = 1'b0;
      res.sck_pulse = 1'b1;
      if (item.cmd != CMD_TICK) begin
        res.status = ST_BUSY;
      end
    end
  end

endmodule

`default_nettype wire
